>>> rtl/tcw_pkg.sv
// Shared constants, codes and controller/datapath interface types of the text console writer.
package tcw_pkg;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;
	localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 6;
	localparam int NCOL_W = 8;
	localparam int NROW_W = 7;
	localparam int ADDR_W = 13;
	localparam int PROD_W = ADDR_W + 1;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [NCOL_W-1:0] NCOL_MAX = NCOL_W'(MAX_COLUMNS);
	localparam logic [NROW_W-1:0] NROW_MAX = NROW_W'(MAX_ROWS);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

	localparam logic [CHAR_W-1:0] NULL_CHAR    = 8'h00;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	localparam logic [NCOL_W-1:0] RESET_COLUMNS = 8'd80;
	localparam logic [NROW_W-1:0] RESET_ROWS    = 7'd25;
	localparam logic [ATTR_W-1:0] RESET_ATTR    = 8'h17;
	localparam logic [CELL_W-1:0] RESET_BLANK   = {RESET_ATTR, BLANK_CHAR};

	// Input modes.
	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CURSOR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 2'd2;

	typedef struct packed {
		logic load_in;
		logic prep;
		logic act;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sweep_idle;
	} status_t;

endpackage

>>> rtl/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
module tcw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  tcw_pkg::status_t status,
	output tcw_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PREP,
		ST_ACT,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = in_valid && in_ready;
		cmd.prep     = (state_q == ST_PREP);
		cmd.act      = (state_q == ST_ACT);
		cmd.out_load = (state_q == ST_DONE) && status.sweep_idle && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (status.sweep_idle) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.load_in) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_ACT;
				ST_ACT:  state_q <= ST_DONE;
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

endmodule

>>> rtl/tcw_datapath.sv
// Datapath of the text console writer: registers, cursor logic, screen memory and sweep unit.
module tcw_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [tcw_pkg::MODE_W-1:0]       mode,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::COL_W-1:0]        col_x,
	input  logic [tcw_pkg::ROW_W-1:0]        row_y,
	input  tcw_pkg::cmd_t                    cmd,
	output tcw_pkg::status_t                 status,
	output logic [tcw_pkg::COL_W-1:0]        cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]        cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]       cursor_offset,
	output logic [tcw_pkg::CELL_W-1:0]       cell_data,
	output logic                             scrolled
);

	// Configuration registers.
	logic [tcw_pkg::NCOL_W-1:0] columns_q;
	logic [tcw_pkg::NROW_W-1:0] rows_q;
	logic [tcw_pkg::ATTR_W-1:0] attr_q;

	// Latched input item.
	logic [tcw_pkg::MODE_W-1:0] mode_q;
	logic [tcw_pkg::CHAR_W-1:0] char_q;
	logic [tcw_pkg::COL_W-1:0]  x_q;
	logic [tcw_pkg::ROW_W-1:0]  y_q;

	// Cursor and per-item state.
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::ROW_W-1:0]  row_q;
	logic [tcw_pkg::ADDR_W-1:0] addr_q;
	logic                       scrolled_q;

	// Output registers.
	logic [tcw_pkg::COL_W-1:0]  out_col_q;
	logic [tcw_pkg::ROW_W-1:0]  out_row_q;
	logic [tcw_pkg::ADDR_W-1:0] out_offset_q;
	logic [tcw_pkg::CELL_W-1:0] out_cell_q;
	logic                       out_scrolled_q;

	// Sweep unit for clear, scroll and the power-up clearing pass.
	logic                       sweep_active_q;
	logic [tcw_pkg::ADDR_W-1:0] idx_q;
	logic [tcw_pkg::ADDR_W-1:0] last_q;
	logic [tcw_pkg::ADDR_W-1:0] copy_end_q;
	logic [tcw_pkg::CELL_W-1:0] blank_q;
	logic                       wr_valid_s1;
	logic [tcw_pkg::ADDR_W-1:0] wr_addr_s1;
	logic                       copy_s1;

	// Screen memory.
	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
	logic [tcw_pkg::CELL_W-1:0] rdata_q;

	logic [tcw_pkg::NCOL_W-1:0] nc;
	logic [tcw_pkg::NROW_W-1:0] nr;
	logic [tcw_pkg::COL_W-1:0]  nc_m1;
	logic [tcw_pkg::ROW_W-1:0]  nr_m1;
	logic [tcw_pkg::COL_W-1:0]  cx;
	logic [tcw_pkg::ROW_W-1:0]  cy;
	logic [tcw_pkg::COL_W-1:0]  cc;
	logic [tcw_pkg::ROW_W-1:0]  cr;
	logic [tcw_pkg::COL_W-1:0]  sel_col;
	logic [tcw_pkg::ROW_W-1:0]  sel_row;
	logic [tcw_pkg::PROD_W-1:0] prep_addr;
	logic [tcw_pkg::PROD_W-1:0] total;
	logic [tcw_pkg::PROD_W-1:0] offset;
	logic [tcw_pkg::NCOL_W-1:0] col_inc;
	logic [tcw_pkg::NROW_W-1:0] row_inc;
	logic                       col_wrap;

	logic [tcw_pkg::COL_W-1:0]  act_col;
	logic [tcw_pkg::NROW_W-1:0] act_row;
	logic                       act_scroll;
	logic                       act_clear;
	logic                       act_wr;
	logic                       act_rd;

	logic                       copy_now;
	logic                       wr_en;
	logic [tcw_pkg::ADDR_W-1:0] wr_addr;
	logic [tcw_pkg::CELL_W-1:0] wr_data;
	logic                       rd_en;
	logic [tcw_pkg::ADDR_W-1:0] rd_addr;

	// A size register of zero acts as one, and oversize values saturate.
	assign nc = (columns_q == '0) ? tcw_pkg::NCOL_W'(1) :
		((columns_q > tcw_pkg::NCOL_MAX) ? tcw_pkg::NCOL_MAX : columns_q);
	assign nr = (rows_q == '0) ? tcw_pkg::NROW_W'(1) :
		((rows_q > tcw_pkg::NROW_MAX) ? tcw_pkg::NROW_MAX : rows_q);
	assign nc_m1 = tcw_pkg::COL_W'(nc - tcw_pkg::NCOL_W'(1));
	assign nr_m1 = tcw_pkg::ROW_W'(nr - tcw_pkg::NROW_W'(1));

	assign cx = ({1'b0, x_q} >= nc) ? nc_m1 : x_q;
	assign cy = ({1'b0, y_q} >= nr) ? nr_m1 : y_q;
	assign cc = ({1'b0, col_q} >= nc) ? nc_m1 : col_q;
	assign cr = ({1'b0, row_q} >= nr) ? nr_m1 : row_q;

	assign sel_col   = (mode_q == tcw_pkg::MODE_READ) ? cx : cc;
	assign sel_row   = (mode_q == tcw_pkg::MODE_READ) ? cy : cr;
	assign prep_addr = tcw_pkg::PROD_W'(sel_row) * tcw_pkg::PROD_W'(nc)
		+ tcw_pkg::PROD_W'(sel_col);
	assign total     = tcw_pkg::PROD_W'(nc) * tcw_pkg::PROD_W'(nr);
	assign offset    = tcw_pkg::PROD_W'(row_q) * tcw_pkg::PROD_W'(nc)
		+ tcw_pkg::PROD_W'(col_q);

	assign col_inc  = {1'b0, col_q} + tcw_pkg::NCOL_W'(1);
	assign row_inc  = {1'b0, row_q} + tcw_pkg::NROW_W'(1);
	assign col_wrap = (col_inc >= nc);

	always_comb begin
		act_col    = col_q;
		act_row    = {1'b0, row_q};
		act_scroll = 1'b0;
		act_clear  = 1'b0;
		act_wr     = 1'b0;
		act_rd     = 1'b0;
		case (mode_q)
			tcw_pkg::MODE_WRITE: begin
				if (char_q != tcw_pkg::NULL_CHAR) begin
					if (char_q == tcw_pkg::NEWLINE_CHAR) begin
						act_row = row_inc;
						act_col = '0;
					end else begin
						act_wr = 1'b1;
						if (col_wrap) begin
							act_row = row_inc;
							act_col = '0;
						end else begin
							act_col = col_inc[tcw_pkg::COL_W-1:0];
						end
					end
					act_scroll = (act_row >= nr);
				end
			end
			tcw_pkg::MODE_CURSOR: begin
				act_col = cx;
				act_row = {1'b0, cy};
			end
			tcw_pkg::MODE_CLEAR: begin
				act_col   = '0;
				act_row   = '0;
				act_clear = 1'b1;
			end
			tcw_pkg::MODE_READ: begin
				act_rd = 1'b1;
			end
			default: begin
				act_rd = 1'b0;
			end
		endcase
	end

	// Sweep writes always go through the s1 stage so a copy lines up with its read data.
	assign copy_now = sweep_active_q && (idx_q < copy_end_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = {attr_q, char_q};
		if (wr_valid_s1) begin
			wr_en   = 1'b1;
			wr_addr = wr_addr_s1;
			wr_data = copy_s1 ? rdata_q : blank_q;
		end else if (cmd.act && act_wr) begin
			wr_en = 1'b1;
		end
	end

	assign rd_en   = copy_now || (cmd.act && act_rd);
	assign rd_addr = sweep_active_q ? (idx_q + tcw_pkg::ADDR_W'(nc)) : addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= tcw_pkg::RESET_COLUMNS;
			rows_q    <= tcw_pkg::RESET_ROWS;
			attr_q    <= tcw_pkg::RESET_ATTR;
		end else if (cfg_we) begin
			case (cfg_index)
				tcw_pkg::REG_COLUMNS:   columns_q <= cfg_data;
				tcw_pkg::REG_ROWS:      rows_q    <= cfg_data[tcw_pkg::NROW_W-1:0];
				tcw_pkg::REG_ATTRIBUTE: attr_q    <= cfg_data;
				default:                attr_q    <= attr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.prep) begin
			col_q <= cc;
			row_q <= cr;
		end else if (cmd.act) begin
			col_q <= act_col;
			row_q <= act_scroll ? nr_m1 : act_row[tcw_pkg::ROW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode;
			char_q <= char_code;
			x_q    <= col_x;
			y_q    <= row_y;
		end
		if (cmd.prep) begin
			addr_q <= prep_addr[tcw_pkg::ADDR_W-1:0];
		end
		if (cmd.act) begin
			scrolled_q <= act_scroll;
		end
		if (cmd.out_load) begin
			out_col_q      <= col_q;
			out_row_q      <= row_q;
			out_offset_q   <= offset[tcw_pkg::ADDR_W-1:0];
			out_cell_q     <= (mode_q == tcw_pkg::MODE_READ) ? rdata_q : '0;
			out_scrolled_q <= scrolled_q;
		end
	end

	// The sweep comes out of reset already running the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_active_q <= 1'b1;
			idx_q          <= '0;
			last_q         <= tcw_pkg::CELL_LAST;
			copy_end_q     <= '0;
			blank_q        <= tcw_pkg::RESET_BLANK;
			wr_valid_s1    <= 1'b0;
			wr_addr_s1     <= '0;
			copy_s1        <= 1'b0;
		end else begin
			wr_valid_s1 <= sweep_active_q;
			wr_addr_s1  <= idx_q;
			copy_s1     <= copy_now;
			if (cmd.act && (act_scroll || act_clear)) begin
				sweep_active_q <= 1'b1;
				idx_q          <= '0;
				last_q         <= tcw_pkg::ADDR_W'(total - tcw_pkg::PROD_W'(1));
				copy_end_q     <= act_scroll ?
					tcw_pkg::ADDR_W'(total - tcw_pkg::PROD_W'(nc)) : '0;
				blank_q        <= {attr_q, tcw_pkg::BLANK_CHAR};
			end else if (sweep_active_q) begin
				idx_q <= idx_q + tcw_pkg::ADDR_W'(1);
				if (idx_q == last_q) begin
					sweep_active_q <= 1'b0;
				end
			end
		end
	end

	assign status.sweep_idle = !sweep_active_q && !wr_valid_s1;

	assign cursor_col    = out_col_q;
	assign cursor_row    = out_row_q;
	assign cursor_offset = out_offset_q;
	assign cell_data     = out_cell_q;
	assign scrolled      = out_scrolled_q;

endmodule

>>> rtl/text_console_writer_top.sv
// Top level of the text console writer: controller, datapath and checks.
//
// Teletype text console holding a 128 x 64 screen of 16-bit cells (attribute high byte,
// character low byte) in one single-port-read, single-port-write memory, plus a cursor.
// Each transfer on the input channel yields exactly one transfer on the output channel.
// Writing a character, setting the cursor and reading a cell pass from input transfer to
// result through the load, clamp-and-address, execute and result steps.
// Clearing the screen and any character that scrolls add a sweep over columns * rows
// cells, since the sweep moves or blanks one memory cell per cycle.
// After reset the block runs a clearing pass over all 8192 cells with in_ready low;
// configuration writes are taken during that time.
module text_console_writer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tcw_pkg::MODE_W-1:0]     mode,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcw_pkg::COL_W-1:0]      col_x,
	input  logic [tcw_pkg::ROW_W-1:0]      row_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tcw_pkg::COL_W-1:0]      cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]     cursor_offset,
	output logic [tcw_pkg::CELL_W-1:0]     cell_data,
	output logic                           scrolled
);

	tcw_pkg::cmd_t    cmd;
	tcw_pkg::status_t status;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tcw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.char_code     (char_code),
		.col_x         (col_x),
		.row_y         (row_y),
		.cmd           (cmd),
		.status        (status),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.cursor_offset (cursor_offset),
		.cell_data     (cell_data),
		.scrolled      (scrolled)
	);

	// No item may be taken while a sweep is still moving or blanking cells.
	a_ready_sweep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> status.sweep_idle)
		else $error("input ready while a memory sweep is running");

	// One item at a time: a transfer closes the input until its result is built.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after a transfer");

	// Only a character write can scroll, and it never returns cell data.
	a_scroll_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (cell_data == '0))
		else $error("scrolled result carries cell data");

endmodule
